>>> design/mmc3m_pkg.sv
// ----------------------------------------------------------------------------
// mmc3m_pkg
// Shared types and constants of the multicart bank mapper.
// ----------------------------------------------------------------------------
package mmc3m_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_PRG   = 2'd1,
        REQ_CHR   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // configuration register index, taken from paddr[2]
    typedef enum logic {
        REG_PRG_MASK = 1'b0,
        REG_CHR_MASK = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } dp_cmd_t;

    localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;
    localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;

    localparam logic [4:0] PRG_MASK_RESET = 5'd31;
    localparam logic [7:0] CHR_MASK_RESET = 8'd255;

    localparam int NUM_INNER = 8;
    typedef logic [7:0] bank_t;
    typedef bank_t [NUM_INNER-1:0] inner_bank_arr_t;

    localparam inner_bank_arr_t INNER_RESET = '{
        8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0
    };

endpackage

>>> design/mmc3m_ctrl.sv
// ----------------------------------------------------------------------------
// mmc3m_ctrl
// Request sequencer: takes a request, runs its execute step, owns out_valid.
// ----------------------------------------------------------------------------
module mmc3m_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output mmc3m_pkg::dp_cmd_t  cmd
);
    import mmc3m_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while output stalled");

    // an accepted request always reaches the execute cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed");

    // a new result only appears right after an execute cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result without execute cycle");

endmodule

>>> design/mmc3m_dp.sv
// ----------------------------------------------------------------------------
// mmc3m_dp
// Mapper datapath: bank registers, mask registers, bank lookup, result regs.
// ----------------------------------------------------------------------------
module mmc3m_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mmc3m_pkg::dp_cmd_t  cmd,
    input  logic [1:0]          req_type,
    input  logic [15:0]         bus_address,
    input  logic [7:0]          write_data,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data,
    output logic [31:0]         cfg_rdata,
    output logic                lookup_valid,
    output logic [7:0]          mapped_bank,
    output logic [17:0]         rom_address
);
    import mmc3m_pkg::*;

    // captured request
    req_t        req_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // mapper state
    logic [4:0]      prg_mask_reg;
    logic [7:0]      chr_mask_reg;
    logic [2:0]      select_index_reg;
    logic            prg_mode_reg;
    logic            chr_mode_reg;
    inner_bank_arr_t inner_reg;
    logic [2:0]      outer_reg;

    // result registers
    logic        lookup_valid_reg, lookup_valid_next;
    logic [7:0]  mapped_bank_reg, mapped_bank_next;
    logic [17:0] rom_address_reg, rom_address_next;

    logic [15:0] addr_decoded;
    logic        wr_select, wr_data, wr_outer;
    logic [1:0]  prg_slot;
    logic [7:0]  prg_second_last;
    logic [7:0]  prg_inner;
    logic [3:0]  prg_keep;
    logic [7:0]  prg_bank;
    logic [2:0]  chr_slot;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_raw;
    logic [7:0]  chr_inner;
    logic [7:0]  chr_bank;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg  <= req_t'(req_type);
            addr_reg <= bus_address;
            data_reg <= write_data;
        end
    end

    // cpu write decode
    assign addr_decoded = addr_reg & ADDR_DECODE_MASK;
    assign wr_select = (req_reg == REQ_WRITE) && (addr_decoded == ADDR_BANK_SELECT);
    assign wr_data   = (req_reg == REQ_WRITE) && (addr_decoded == ADDR_BANK_DATA);
    assign wr_outer  = (req_reg == REQ_WRITE) && (addr_reg[15:13] == 3'b011);

    // prg lookup
    assign prg_slot        = addr_reg[14:13];
    assign prg_second_last = {3'b000, prg_mask_reg} - 8'd1;

    always_comb
    begin
        case (prg_slot)
            2'd1:    prg_inner = inner_reg[7];
            2'd3:    prg_inner = {3'b000, prg_mask_reg};
            default:
            begin
                if ((prg_slot == 2'd0) == !prg_mode_reg)
                    prg_inner = inner_reg[6];
                else
                    prg_inner = prg_second_last;
            end
        endcase
    end

    // outer bit 2 sets bit 4 and opens the fourth inner bit, outer bits 1:0 both set force bit 3
    assign prg_keep = {outer_reg[2], 3'b111};
    assign prg_bank = {3'b000,
                       (outer_reg[2] | (prg_inner[4] & 1'b0)),
                       ((outer_reg[1:0] == 2'b11) | (prg_inner[3] & prg_keep[3])),
                       prg_inner[2:0] & prg_keep[2:0]}
                      & {3'b000, prg_mask_reg};

    // chr lookup; mode bit swaps the two halves of the pattern space
    assign chr_slot  = addr_reg[12:10] ^ {chr_mode_reg, 2'b00};
    assign chr_idx   = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
    assign chr_raw   = inner_reg[chr_idx];
    assign chr_inner = chr_slot[2] ? chr_raw : {chr_raw[7:1], chr_slot[0]};
    assign chr_bank  = {outer_reg[2], chr_inner[6:0]} & chr_mask_reg;

    always_comb
    begin
        lookup_valid_next = 1'b0;
        mapped_bank_next  = '0;
        rom_address_next  = '0;
        case (req_reg)
            REQ_PRG:
            begin
                if (addr_reg[15])
                begin
                    lookup_valid_next = 1'b1;
                    mapped_bank_next  = prg_bank;
                    rom_address_next  = {prg_bank[4:0], addr_reg[12:0]};
                end
            end
            REQ_CHR:
            begin
                if (addr_reg[15:13] == 3'b000)
                begin
                    lookup_valid_next = 1'b1;
                    mapped_bank_next  = chr_bank;
                    rom_address_next  = {chr_bank, addr_reg[9:0]};
                end
            end
            default:
            begin
                lookup_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            lookup_valid_reg <= lookup_valid_next;
            mapped_bank_reg  <= mapped_bank_next;
            rom_address_reg  <= rom_address_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_mask_reg     <= PRG_MASK_RESET;
            chr_mask_reg     <= CHR_MASK_RESET;
            select_index_reg <= '0;
            prg_mode_reg     <= 1'b0;
            chr_mode_reg     <= 1'b0;
            inner_reg        <= INNER_RESET;
            outer_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PRG_MASK: prg_mask_reg <= cfg_data[4:0];
                    REG_CHR_MASK: chr_mask_reg <= cfg_data[7:0];
                    default:      prg_mask_reg <= prg_mask_reg;
                endcase
            end
            if (cmd.exec)
            begin
                if (wr_select)
                begin
                    select_index_reg <= data_reg[2:0];
                    prg_mode_reg     <= data_reg[6];
                    chr_mode_reg     <= data_reg[7];
                end
                if (wr_data)
                    inner_reg[select_index_reg] <= data_reg;
                if (wr_outer)
                    outer_reg <= data_reg[2:0];
            end
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(cfg_index))
            REG_PRG_MASK: cfg_rdata = {27'd0, prg_mask_reg};
            REG_CHR_MASK: cfg_rdata = {24'd0, chr_mask_reg};
            default:      cfg_rdata = '0;
        endcase
    end

    assign lookup_valid = lookup_valid_reg;
    assign mapped_bank  = mapped_bank_reg;
    assign rom_address  = rom_address_reg;

    // prg banks never exceed the 5-bit prg mask
    a_prg_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && req_reg == REQ_PRG) |=> (mapped_bank_reg[7:5] == 3'b000))
        else $error("prg bank beyond mask width");

    // a write request never produces a mapping
    a_write_no_map: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && req_reg == REQ_WRITE) |=> !lookup_valid_reg)
        else $error("write request produced a mapping");

    // lookups leave the mapper state alone
    a_lookup_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (req_reg == REQ_PRG || req_reg == REQ_CHR) && !cfg_write)
        |=> ($stable(inner_reg) && $stable(outer_reg) && $stable(select_index_reg)))
        else $error("lookup changed mapper state");

endmodule

>>> design/mmc3_outer_bank_mapper.sv
// ----------------------------------------------------------------------------
// mmc3_outer_bank_mapper
// MMC3-style multicart bank mapper with a 3-bit outer bank register.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one request: a cpu write
// (bank select, bank data, outer register), a prg lookup or a chr lookup.
// Output channel (out_valid/out_ready) returns exactly one result per
// request: lookup_valid, mapped_bank and rom_address, all zero for writes
// and for addresses outside the lookup window.
// The request is captured at the accepting edge; then the execute state
// updates the mapper state, loads the result register and sets out_valid.
// A new request is taken only after the previous one has left the execute
// state; the capture/execute sequence of the controller sets this.
// If the receiver stalls, the result stays in the output register and one
// more request is still accepted; its execute cycle waits until the slot
// frees, and input acceptance pauses behind it.
// The APB port holds prg_bank_mask (address 0) and chr_bank_mask
// (address 4). Reset restores all masks, modes and inner bank registers,
// and leaves no result pending.
// ----------------------------------------------------------------------------
module mmc3_outer_bank_mapper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        lookup_valid,
    output logic [7:0]  mapped_bank,
    output logic [17:0] rom_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mmc3m_pkg::*;

    dp_cmd_t cmd;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    mmc3m_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mmc3m_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req_type),
        .bus_address  (bus_address),
        .write_data   (write_data),
        .cfg_write    (cfg_write),
        .cfg_index    (paddr[2]),
        .cfg_data     (pwdata),
        .cfg_rdata    (prdata),
        .lookup_valid (lookup_valid),
        .mapped_bank  (mapped_bank),
        .rom_address  (rom_address)
    );

    // a result without a mapping carries all-zero fields
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !lookup_valid) |-> (mapped_bank == 8'd0 && rom_address == 18'd0))
        else $error("non-mapping result has nonzero fields");

    // the rom address always starts with the mapped bank
    a_bank_in_address: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && lookup_valid) |->
        (rom_address[17:10] == mapped_bank ||
         (rom_address[17:13] == mapped_bank[4:0] && mapped_bank[7:5] == 3'b000)))
        else $error("rom address does not match mapped bank");

endmodule
